// ===== hdl/variable_partition_allocator_macros.svh =====
// Assertion macros for the variable partition allocator.
`ifndef VARIABLE_PARTITION_ALLOCATOR_MACROS_SVH
`define VARIABLE_PARTITION_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define VPA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define VPA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define VPA_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define VPA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/vpa_pkg.sv =====
`timescale 1ns / 1ps
package vpa_pkg;

   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int ADDR_BITS_DEF    = 16;
   localparam int CSR_ADDR_W       = 3;
   localparam logic [15:0] RESET_TOTAL = 16'hFFFF;

   typedef enum logic [1:0] {
      FUNC_FIRST = 2'd0,
      FUNC_BEST  = 2'd1,
      FUNC_WORST = 2'd2,
      FUNC_FREE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_NOFIT  = 2'd1,
      ST_NOUSED = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_INIT,
      CMD_INSERT,
      CMD_MARK,
      CMD_MERGE
   } cmd_op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_MERGE_R,
      S_MERGE_L,
      S_RESP
   } state_type;

   typedef struct packed {
      cmd_op_type op;
      logic       used;
   } cell_cmd_type;

   typedef struct packed {
      logic hit;
      logic just_hit;
      logic last_free;
      logic prev_free;
      logic next_free;
   } tok_flags_type;

endpackage

// ===== hdl/vpa_req_if.sv =====
`timescale 1ns / 1ps
interface vpa_req_if #(parameter int ADDR_BITS = 16);
   logic                 valid;
   logic                 ready;
   logic [1:0]           func;
   logic [ADDR_BITS-1:0] req_size;
   logic [ADDR_BITS-1:0] free_addr;

   modport source (output valid, func, req_size, free_addr, input ready);
   modport sink   (input valid, func, req_size, free_addr, output ready);
endinterface

// ===== hdl/vpa_rsp_if.sv =====
`timescale 1ns / 1ps
interface vpa_rsp_if #(parameter int ADDR_BITS = 16);
   logic                 valid;
   logic                 ready;
   logic [1:0]           status;
   logic [ADDR_BITS-1:0] addr;

   modport source (output valid, status, addr, input ready);
   modport sink   (input valid, status, addr, output ready);
endinterface

// ===== hdl/vpa_cell.sv =====
`timescale 1ns / 1ps
module vpa_cell #(
   parameter int ADDR_BITS = 16,
   parameter int IDX_W     = 6,
   parameter int INDEX     = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  vpa_pkg::cell_cmd_type  cmd,
   input  logic [IDX_W-1:0]       cmd_idx,
   input  logic [ADDR_BITS-1:0]   cmd_val,
   input  vpa_pkg::func_type      policy,
   input  logic [ADDR_BITS-1:0]   scan_need,
   input  logic [ADDR_BITS-1:0]   scan_addr,
   input  logic [ADDR_BITS-1:0]   left_start,
   input  logic [ADDR_BITS-1:0]   left_size,
   input  logic                   left_used,
   input  logic                   left_valid,
   input  logic [ADDR_BITS-1:0]   right_start,
   input  logic [ADDR_BITS-1:0]   right_size,
   input  logic                   right_used,
   input  logic                   right_valid,
   input  vpa_pkg::tok_flags_type tok_in,
   input  logic [IDX_W-1:0]       tok_idx_in,
   input  logic [ADDR_BITS-1:0]   tok_size_in,
   input  logic [ADDR_BITS-1:0]   tok_start_in,
   output logic [ADDR_BITS-1:0]   seg_start,
   output logic [ADDR_BITS-1:0]   seg_size,
   output logic                   seg_used,
   output logic                   seg_valid,
   output vpa_pkg::tok_flags_type tok_out,
   output logic [IDX_W-1:0]       tok_idx_out,
   output logic [ADDR_BITS-1:0]   tok_size_out,
   output logic [ADDR_BITS-1:0]   tok_start_out
);
   import vpa_pkg::*;

   localparam logic [IDX_W:0] MY = (IDX_W+1)'(INDEX);

   logic [ADDR_BITS-1:0] start_ff, start_in, size_ff, size_in;
   logic                 used_ff, used_in, valid_ff, valid_in;
   tok_flags_type        tok_ff, tok_next_in;
   logic [IDX_W-1:0]     tidx_ff, tidx_in;
   logic [ADDR_BITS-1:0] tsize_ff, tsize_in, tstart_ff, tstart_in;
   logic [IDX_W:0]       k, k1;
   logic                 my_free, fits, take;

   assign k  = {1'b0, cmd_idx};
   assign k1 = k + 1'b1;

   always_comb begin
      start_in = start_ff;
      size_in  = size_ff;
      used_in  = used_ff;
      valid_in = valid_ff;
      case (cmd.op)
         CMD_INIT: begin
            start_in = '0;
            size_in  = cmd_val;
            used_in  = 1'b0;
            valid_in = (INDEX == 0);
         end
         CMD_INSERT: begin
            if (MY == k) begin
               size_in = cmd_val;
               used_in = 1'b1;
            end else if (MY == k1) begin
               start_in = left_start + cmd_val;
               size_in  = left_size - cmd_val;
               used_in  = 1'b0;
               valid_in = 1'b1;
            end else if (MY > k1) begin
               start_in = left_start;
               size_in  = left_size;
               used_in  = left_used;
               valid_in = left_valid;
            end
         end
         CMD_MARK: begin
            if (MY == k) used_in = cmd.used;
         end
         CMD_MERGE: begin
            if (MY == k) begin
               size_in = size_ff + right_size;
            end else if (MY > k) begin
               start_in = right_start;
               size_in  = right_size;
               used_in  = right_used;
               valid_in = right_valid;
            end
         end
         default: ;
      endcase
   end

   assign my_free = valid_ff && !used_ff;
   assign fits    = my_free && (size_ff >= scan_need) && (scan_need != '0);

   always_comb begin
      case (policy)
         FUNC_FIRST: take = fits && !tok_in.hit;
         FUNC_BEST:  take = fits && (!tok_in.hit || size_ff < tok_size_in);
         FUNC_WORST: take = fits && (!tok_in.hit || size_ff > tok_size_in);
         FUNC_FREE:  take = valid_ff && used_ff && (start_ff == scan_addr) && !tok_in.hit;
         default:    take = 1'b0;
      endcase
      tok_next_in.hit       = tok_in.hit || take;
      tok_next_in.just_hit  = take;
      tok_next_in.last_free = my_free;
      tok_next_in.prev_free = take ? tok_in.last_free : tok_in.prev_free;
      tok_next_in.next_free = tok_in.just_hit ? my_free : tok_in.next_free;
      tidx_in   = take ? IDX_W'(INDEX) : tok_idx_in;
      tsize_in  = take ? size_ff : tok_size_in;
      tstart_in = take ? start_ff : tok_start_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         size_ff   <= ADDR_BITS'(RESET_TOTAL);
         used_ff   <= 1'b0;
         valid_ff  <= (INDEX == 0);
         tok_ff    <= '0;
      end else begin
         start_ff  <= start_in;
         size_ff   <= size_in;
         used_ff   <= used_in;
         valid_ff  <= valid_in;
         tok_ff    <= tok_next_in;
      end
      tidx_ff   <= tidx_in;
      tsize_ff  <= tsize_in;
      tstart_ff <= tstart_in;
   end

   assign seg_start     = start_ff;
   assign seg_size      = size_ff;
   assign seg_used      = used_ff;
   assign seg_valid     = valid_ff;
   assign tok_out       = tok_ff;
   assign tok_idx_out   = tidx_ff;
   assign tok_size_out  = tsize_ff;
   assign tok_start_out = tstart_ff;

endmodule

// ===== hdl/variable_partition_allocator.sv =====
`timescale 1ns / 1ps
// Variable partition allocator: first, best or worst fit with coalescing.
// req_chan takes one transaction (func, req_size, free_addr); rsp_chan
// returns one transaction (status, addr) for each. The segment table sits
// in a row of MAX_SEGMENTS cells; a search token walks down the row one
// cell per cycle and the result is registered when it leaves the last
// cell; a free that finds its segment then passes through the merge
// states S_MERGE_R and S_MERGE_L. Inserts and merges shift every cell
// above the affected index in the same cycle. One transaction is in flight at a
// time; req_chan.ready is low until the result has been taken and rises
// the cycle after, so no new transaction starts before the last result
// is taken. A stalled rsp_chan holds the result steady.
// Reset gives one free segment of 65535 units. Writing total_size at
// address 0 of the csr port rebuilds the table as one free segment; it is
// written only while the block is idle. Reads return total_size.
module variable_partition_allocator #(
   parameter int MAX_SEGMENTS = vpa_pkg::MAX_SEGMENTS_DEF,
   parameter int ADDR_BITS    = vpa_pkg::ADDR_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   vpa_req_if.sink                         req_chan,
   vpa_rsp_if.source                       rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [vpa_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import vpa_pkg::*;
   `include "variable_partition_allocator_macros.svh"

   localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in, count_ff, count_in;
   func_type             func_ff, func_in;
   logic [ADDR_BITS-1:0] need_ff, need_in, faddr_ff, faddr_in;
   logic [ADDR_BITS-1:0] total_ff, total_in;
   tok_flags_type        res_ff, res_in;
   logic [IDX_W-1:0]     ridx_ff, ridx_in;
   logic [ADDR_BITS-1:0] rsize_ff, rsize_in, rstart_ff, rstart_in;
   status_type           status_ff, status_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;

   cell_cmd_type         cmd;
   logic [IDX_W-1:0]     cmd_idx;
   logic [ADDR_BITS-1:0] cmd_val;
   logic                 req_fire, cfg_write;

   logic [ADDR_BITS-1:0] s_start [0:MAX_SEGMENTS+1];
   logic [ADDR_BITS-1:0] s_size  [0:MAX_SEGMENTS+1];
   logic                 s_used  [0:MAX_SEGMENTS+1];
   logic                 s_valid [0:MAX_SEGMENTS+1];
   tok_flags_type        t_flags [0:MAX_SEGMENTS];
   logic [IDX_W-1:0]     t_idx   [0:MAX_SEGMENTS];
   logic [ADDR_BITS-1:0] t_size  [0:MAX_SEGMENTS];
   logic [ADDR_BITS-1:0] t_start [0:MAX_SEGMENTS];

   assign s_start[0] = '0;
   assign s_size[0]  = '0;
   assign s_used[0]  = 1'b0;
   assign s_valid[0] = 1'b0;
   assign s_start[MAX_SEGMENTS+1] = '0;
   assign s_size[MAX_SEGMENTS+1]  = '0;
   assign s_used[MAX_SEGMENTS+1]  = 1'b0;
   assign s_valid[MAX_SEGMENTS+1] = 1'b0;
   assign t_flags[0] = '0;
   assign t_idx[0]   = '0;
   assign t_size[0]  = '0;
   assign t_start[0] = '0;

   for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
      vpa_cell #(.ADDR_BITS(ADDR_BITS), .IDX_W(IDX_W), .INDEX(i)) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .cmd_idx      (cmd_idx),
         .cmd_val      (cmd_val),
         .policy       (func_ff),
         .scan_need    (need_ff),
         .scan_addr    (faddr_ff),
         .left_start   (s_start[i]),
         .left_size    (s_size[i]),
         .left_used    (s_used[i]),
         .left_valid   (s_valid[i]),
         .right_start  (s_start[i+2]),
         .right_size   (s_size[i+2]),
         .right_used   (s_used[i+2]),
         .right_valid  (s_valid[i+2]),
         .tok_in       (t_flags[i]),
         .tok_idx_in   (t_idx[i]),
         .tok_size_in  (t_size[i]),
         .tok_start_in (t_start[i]),
         .seg_start    (s_start[i+1]),
         .seg_size     (s_size[i+1]),
         .seg_used     (s_used[i+1]),
         .seg_valid    (s_valid[i+1]),
         .tok_out      (t_flags[i+1]),
         .tok_idx_out  (t_idx[i+1]),
         .tok_size_out (t_size[i+1]),
         .tok_start_out(t_start[i+1])
      );
   end

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                      (csr_paddr[2] == 1'b0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (req_fire) state_in = S_SCAN;
         S_SCAN:    if (cnt_ff == CNT_MAX) state_in = S_DECIDE;
         S_DECIDE:  state_in = (func_ff == FUNC_FREE && res_ff.hit) ? S_MERGE_R : S_RESP;
         S_MERGE_R: state_in = S_MERGE_L;
         S_MERGE_L: state_in = S_RESP;
         S_RESP:    if (rsp_chan.ready) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cnt_in    = cnt_ff;
      count_in  = count_ff;
      func_in   = func_ff;
      need_in   = need_ff;
      faddr_in  = faddr_ff;
      total_in  = total_ff;
      res_in    = res_ff;
      ridx_in   = ridx_ff;
      rsize_in  = rsize_ff;
      rstart_in = rstart_ff;
      status_in = status_ff;
      addr_in   = addr_ff;
      cmd       = '{op: CMD_NONE, used: 1'b0};
      cmd_idx   = ridx_ff;
      cmd_val   = need_ff;
      case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_fire) begin
               func_in  = func_type'(req_chan.func);
               need_in  = req_chan.req_size;
               faddr_in = req_chan.free_addr;
            end
            if (cfg_write) begin
               total_in = csr_pwdata[ADDR_BITS-1:0];
               count_in = CNT_W'(1);
               cmd      = '{op: CMD_INIT, used: 1'b0};
               cmd_val  = csr_pwdata[ADDR_BITS-1:0];
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_MAX) begin
               res_in    = t_flags[MAX_SEGMENTS];
               ridx_in   = t_idx[MAX_SEGMENTS];
               rsize_in  = t_size[MAX_SEGMENTS];
               rstart_in = t_start[MAX_SEGMENTS];
            end
         end
         S_DECIDE: begin
            addr_in = '0;
            if (func_ff == FUNC_FREE) begin
               if (res_ff.hit) begin
                  status_in = ST_OK;
                  addr_in   = faddr_ff;
                  cmd       = '{op: CMD_MARK, used: 1'b0};
               end else begin
                  status_in = ST_NOUSED;
               end
            end else if (!res_ff.hit) begin
               status_in = ST_NOFIT;
            end else if (rsize_ff > need_ff) begin
               if (count_ff == CNT_MAX) begin
                  status_in = ST_FULL;
               end else begin
                  status_in = ST_OK;
                  addr_in   = rstart_ff;
                  count_in  = count_ff + 1'b1;
                  cmd       = '{op: CMD_INSERT, used: 1'b1};
               end
            end else begin
               status_in = ST_OK;
               addr_in   = rstart_ff;
               cmd       = '{op: CMD_MARK, used: 1'b1};
            end
         end
         S_MERGE_R: begin
            if (res_ff.next_free) begin
               cmd      = '{op: CMD_MERGE, used: 1'b0};
               count_in = count_ff - 1'b1;
            end
         end
         S_MERGE_L: begin
            cmd_idx = ridx_ff - 1'b1;
            if (res_ff.prev_free) begin
               cmd      = '{op: CMD_MERGE, used: 1'b0};
               count_in = count_ff - 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         count_ff <= CNT_W'(1);
         total_ff <= ADDR_BITS'(RESET_TOTAL);
         res_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         count_ff <= count_in;
         total_ff <= total_in;
         res_ff   <= res_in;
      end
      func_ff   <= func_in;
      need_ff   <= need_in;
      faddr_ff  <= faddr_in;
      ridx_ff   <= ridx_in;
      rsize_ff  <= rsize_in;
      rstart_ff <= rstart_in;
      status_ff <= status_in;
      addr_ff   <= addr_in;
   end

   assign req_chan.ready  = (state_ff == S_IDLE);
   assign rsp_chan.valid  = (state_ff == S_RESP);
   assign rsp_chan.status = status_ff;
   assign rsp_chan.addr   = addr_ff;
   assign csr_pready      = 1'b1;
   assign csr_prdata      = 32'(total_ff);

   `VPA_ASSERT_SAME(a_count_range, clock, reset, 1'b1,
                    count_ff != '0 && count_ff <= CNT_MAX)
   `VPA_ASSERT_NEXT(a_accept_scan, clock, reset, req_fire, state_ff == S_SCAN)
   `VPA_ASSERT_SAME(a_fail_addr, clock, reset,
                    rsp_chan.valid && rsp_chan.status != ST_OK, rsp_chan.addr == '0)
   `VPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_chan.valid && !rsp_chan.ready,
                    rsp_chan.valid && $stable(rsp_chan.addr))

endmodule
